@@ design/text_console_writer_assert.svh @@
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tcw_pkg.sv @@
package tcw_pkg;

	localparam int CHAR_W    = 8;
	localparam int CELL_W    = 16;
	localparam int ADDR_IN_W = 11;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// word index of a register (paddr[2])
	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic sweep_step;
		logic sweep_clear;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic scroll;
	} tcw_sts_t;

endpackage

@@ design/tcw_ctrl.sv @@
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  tcw_sts_t sts,
	output tcw_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_BLANK  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_FINISH) && out_free);
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.load_item   = accept;
	assign cmd.exec        = (state_q == S_EXEC);
	assign cmd.sweep_step  = (state_q == S_CLEAR) || (state_q == S_BLANK);
	assign cmd.sweep_clear = (state_q == S_CLEAR);
	assign cmd.load_out    = (state_q == S_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.sweep_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = sts.scroll ? S_BLANK : S_FINISH;
			end
			S_BLANK: begin
				if (sts.sweep_last)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free)
					state_d = accept ? S_EXEC : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`TCW_ASSERT_NOW(a_no_take_in_sweep, cmd.sweep_step, !in_ready, "item taken during a sweep")
	`TCW_ASSERT_NEXT(a_accept_to_exec, accept, state_q == S_EXEC, "accepted item not executed")
	`TCW_ASSERT_NEXT(a_exec_no_scroll, (state_q == S_EXEC) && !sts.scroll,
		state_q == S_FINISH, "plain item did not go to finish")

endmodule

@@ design/tcw_datapath.sv @@
`include "text_console_writer_assert.svh"

module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_cmd_t             cmd,
	output tcw_sts_t             sts,
	input  logic [CHAR_W-1:0]    attr,
	input  logic                 operation,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [ADDR_IN_W-1:0] cell_address,
	output logic [CELL_W-1:0]    cell_value,
	output logic [COL_OUT_W-1:0] cursor_col,
	output logic [ROW_OUT_W-1:0] cursor_row,
	output logic                 scrolled
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int SUM_W  = ((ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W) + 1;

	localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] COLS_A         = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_COL_A     = ADDR_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
	localparam logic [SUM_W-1:0]  CELLS_S        = SUM_W'(CELLS);
	localparam logic [ADDR_W:0]   CELLS_W        = (ADDR_W + 1)'(CELLS);

	logic [CELL_W-1:0] mem [CELLS];

	logic                 op_q;
	logic [CHAR_W-1:0]    ch_q;
	logic [ADDR_IN_W-1:0] addr_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [ADDR_W-1:0]    pos_q;   // logical cell of the cursor
	logic [ADDR_W-1:0]    base_q;  // physical start of the top row
	logic [ADDR_W-1:0]    sweep_addr_q;
	logic [ADDR_W-1:0]    sweep_end_q;
	logic [CELL_W-1:0]    rd_q;
	logic                 rd_ok_q;
	logic                 scroll_q;
	logic [CELL_W-1:0]    cell_value_q;
	logic [COL_W-1:0]     col_out_q;
	logic [ROW_W-1:0]     row_out_q;
	logic                 scrolled_q;

	logic              is_nl;
	logic              adv_line;
	logic              at_last_row;
	logic              scroll;
	logic [ADDR_W-1:0] row_start;
	logic [ADDR_W:0]   wr_sum;
	logic [ADDR_W-1:0] phys_wr;
	logic [SUM_W-1:0]  rd_sum;
	logic [SUM_W-1:0]  rd_wrap;
	logic [ADDR_W-1:0] phys_rd;
	logic              rd_in_range;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [CELL_W-1:0] mem_wdata;

	assign is_nl       = (ch_q == NEWLINE_CODE);
	assign at_last_row = (row_q == LAST_ROW);
	assign adv_line    = (op_q == OP_WRITE) && (is_nl || (col_q == LAST_COL));
	assign scroll      = adv_line && at_last_row;
	assign row_start   = pos_q - ADDR_W'(col_q);

	// scrolling only rotates the row origin, so logical cells map by add and wrap
	assign wr_sum  = {1'b0, pos_q} + {1'b0, base_q};
	assign phys_wr = (wr_sum >= CELLS_W) ? ADDR_W'(wr_sum - CELLS_W) : ADDR_W'(wr_sum);

	assign rd_in_range = (SUM_W'(addr_q) < CELLS_S);
	assign rd_sum      = SUM_W'(addr_q) + SUM_W'(base_q);
	assign rd_wrap     = (rd_sum >= CELLS_S) ? (rd_sum - CELLS_S) : rd_sum;
	assign phys_rd     = rd_wrap[ADDR_W-1:0];

	assign mem_we = cmd.sweep_step || (cmd.exec && (op_q == OP_WRITE) && !is_nl);
	assign mem_re = cmd.exec && (op_q == OP_READ);

	always_comb begin
		if (cmd.sweep_step)
			mem_addr = sweep_addr_q;
		else if (op_q == OP_READ)
			mem_addr = phys_rd;
		else
			mem_addr = phys_wr;
	end

	always_comb begin
		if (cmd.sweep_step)
			mem_wdata = cmd.sweep_clear ? {RESET_ATTR, SPACE_CODE} : {attr, SPACE_CODE};
		else
			mem_wdata = {attr, ch_q};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_addr];
	end

	assign sts.sweep_last = (sweep_addr_q == sweep_end_q);
	assign sts.scroll     = scroll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
			base_q       <= '0;
			sweep_addr_q <= '0;
			sweep_end_q  <= LAST_CELL;
		end else begin
			if (cmd.sweep_step)
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
			if (cmd.exec && (op_q == OP_WRITE)) begin
				if (adv_line) begin
					col_q <= '0;
					if (at_last_row) begin
						pos_q        <= row_start;
						// the old top row becomes the bottom row and gets blanked
						base_q       <= (base_q == LAST_ROW_START) ? '0 : base_q + COLS_A;
						sweep_addr_q <= base_q;
						sweep_end_q  <= base_q + LAST_COL_A;
					end else begin
						row_q <= row_q + ROW_W'(1);
						pos_q <= row_start + COLS_A;
					end
				end else begin
					col_q <= col_q + COL_W'(1);
					pos_q <= pos_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= operation;
			ch_q   <= char_code;
			addr_q <= cell_address;
		end
		if (cmd.exec) begin
			rd_ok_q  <= rd_in_range;
			scroll_q <= scroll;
		end
		if (cmd.load_out) begin
			cell_value_q <= ((op_q == OP_READ) && rd_ok_q) ? rd_q : '0;
			col_out_q    <= col_q;
			row_out_q    <= row_q;
			scrolled_q   <= (op_q == OP_WRITE) && scroll_q;
		end
	end

	assign cell_value = cell_value_q;
	assign cursor_col = COL_OUT_W'(col_out_q);
	assign cursor_row = ROW_OUT_W'(row_out_q);
	assign scrolled   = scrolled_q;

	`TCW_ASSERT_NOW(a_col_range, 1'b1, col_q <= LAST_COL, "cursor column past last column")
	`TCW_ASSERT_NOW(a_row_range, 1'b1, row_q <= LAST_ROW, "cursor row past last row")
	`TCW_ASSERT_NEXT(a_blank_span, cmd.exec && scroll,
		(sweep_end_q - sweep_addr_q) == LAST_COL_A, "blank sweep not one row long")

endmodule

@@ design/text_console_writer.sv @@
// Channel  | Handshake                         | Payload
// config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
// input    | in_valid, in_ready                | operation, char_code, cell_address
// output   | out_valid, out_ready              | cell_value, cursor_col, cursor_row, scrolled
//
// After reset a clearing pass writes all COLUMNS*ROWS cells (2000 by default),
// before in_ready rises; configuration writes are taken throughout.
// An item is loaded at acceptance, uses the single screen memory port in the execute step,
// then loads the output register in the finish step, where the next item can already be taken.
// A scroll rotates the row origin and blanks one row in a sweep before the finish step.
// A stalled result holds the next item in the finish step until out_ready.
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [ADDR_IN_W-1:0] cell_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CELL_W-1:0]    cell_value,
	output logic [COL_OUT_W-1:0] cursor_col,
	output logic [ROW_OUT_W-1:0] cursor_row,
	output logic                 scrolled
);

	tcw_cmd_t          cmd;
	tcw_sts_t          sts;
	logic [CHAR_W-1:0] attr_q;
	logic              cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);
	assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= RESET_ATTR;
		else if (cfg_write)
			attr_q <= pwdata[CHAR_W-1:0];
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.attr         (attr_q),
		.operation    (operation),
		.char_code    (char_code),
		.cell_address (cell_address),
		.cell_value   (cell_value),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.scrolled     (scrolled)
	);

	`TCW_ASSERT_NEXT(a_attr_write, cfg_write, attr_q == $past(pwdata[CHAR_W-1:0]),
		"attribute write lost")
	`TCW_ASSERT_NOW(a_no_take_busy, cmd.exec, !in_ready, "item taken while one executes")
	`TCW_ASSERT_NOW(a_read_zero, out_valid && !(cell_value == '0), !scrolled,
		"read result flagged as scroll")

endmodule
